// ===== src/fsa_pkg.sv =====
package fsa_pkg;

    typedef enum logic [2:0] {
        ST_REUSED   = 3'd0,
        ST_CARVED   = 3'd1,
        ST_NEWBUF   = 3'd2,
        ST_NOSPACE  = 3'd3,
        ST_BADSIZE  = 3'd4,
        ST_RELEASED = 3'd5,
        ST_BADSLOT  = 3'd6
    } t_status;

    localparam logic KIND_GET     = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

endpackage

// ===== src/formatted_slot_allocator.sv =====
// Slot allocator with one LIFO free list per format and size class. After reset
// a clearing pass writes zero to all NUM_FORMATS * NUM_SIZE_CLASSES free-list
// heads, and no item is accepted during it. Items are handled one at a time.
// From the accepting edge to the edge that raises m_axis_tvalid:
// - A get reads its free-list head (S_HEAD, S_HEADW) and on a hit pops (S_POP).
// - A get that misses goes through S_WALK to S_CHECK when its format has no
//   buffer. Otherwise it passes S_WALKW and S_CHECK per buffer, up to NUM_BUFFERS.
// - A release passes S_RELRD, S_RELBUF, S_RELHD and S_RELW.
// - A rejected item goes straight to S_OUT. Every path ends in S_OUT.
// The block is ready again in the cycle after that, and a finished result may
// wait at the output while the next item is taken in. Every step goes through
// one read port of each state memory.
module formatted_slot_allocator
    import fsa_pkg::*;
#(
    parameter int NUM_FORMATS      = 18,
    parameter int NUM_SIZE_CLASSES = 512,
    parameter int NUM_SLOTS        = 4096,
    parameter int NUM_BUFFERS      = 32,
    parameter int GRAIN_SHIFT      = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // kind[0].
    input  logic        s_axis_tuser,
    // format[4:0], request_size[19:5], slot_id[31:20].
    input  logic [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[2:0], granted_slot[14:3], buffer_id[19:15], start_offset[35:20],
    // granted_size[50:36], zeros above.
    output logic [55:0] m_axis_tdata
);
    localparam int HC  = NUM_FORMATS * NUM_SIZE_CLASSES;
    localparam int HW  = $clog2(HC);
    localparam int SW  = $clog2(NUM_SLOTS);
    localparam int BW  = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
    localparam int CW  = (NUM_SIZE_CLASSES > 1) ? $clog2(NUM_SIZE_CLASSES) : 1;
    localparam int FW  = (NUM_FORMATS > 1) ? $clog2(NUM_FORMATS) : 1;
    localparam int LW  = 18;

    typedef enum logic [12:0] {
        S_CLEAR  = 13'b0000000000001,
        S_IDLE   = 13'b0000000000010,
        S_HEAD   = 13'b0000000000100,
        S_HEADW  = 13'b0000000001000,
        S_POP    = 13'b0000000010000,
        S_WALK   = 13'b0000000100000,
        S_WALKW  = 13'b0000001000000,
        S_CHECK  = 13'b0000010000000,
        S_RELRD  = 13'b0000100000000,
        S_RELBUF = 13'b0001000000000,
        S_RELHD  = 13'b0010000000000,
        S_RELW   = 13'b0100000000000,
        S_OUT    = 13'b1000000000000
    } t_state;

    t_state r_state;
    logic [15:0] r_cap;
    logic [HW-1:0] r_clr;
    logic [SW:0] r_slots_used;
    logic [BW:0] r_bufs_used;
    logic [BW:0] r_newest [NUM_FORMATS];
    logic [FW-1:0] r_fmt;
    logic [CW-1:0] r_cls;
    logic [15:0] r_size;
    logic [BW:0] r_cur;
    logic [BW:0] r_steps;
    logic [SW-1:0] r_id;
    logic [HW-1:0] r_h;
    logic [55:0] r_out;
    logic [55:0] r_tdata;

    // Memories.
    logic          hd_we;
    logic [HW-1:0] hd_wa, hd_ra;
    logic [SW:0]   hd_wd, hd_rd;
    logic          sl_we;
    logic [SW-1:0] sl_wa, sl_ra;
    logic [SW:0]   lk_wd, lk_rd;
    logic          si_we;
    logic [CW+BW+16-1:0] si_wd, si_rd;
    logic          bf_we;
    logic [BW-1:0] bf_wa, bf_ra;
    logic [LW-1:0] fl_wd, fl_rd;
    logic          bi_we;
    logic [LW+BW+1+FW-1:0] bi_wd, bi_rd;

    fsa_ram #(.WIDTH(SW+1), .DEPTH(HC)) u_head (
        .i_clk(i_clk), .i_we(hd_we), .i_waddr(hd_wa), .i_wdata(hd_wd),
        .i_raddr(hd_ra), .o_rdata(hd_rd));
    fsa_ram #(.WIDTH(SW+1), .DEPTH(NUM_SLOTS)) u_link (
        .i_clk(i_clk), .i_we(sl_we), .i_waddr(sl_wa), .i_wdata(lk_wd),
        .i_raddr(sl_ra), .o_rdata(lk_rd));
    fsa_ram #(.WIDTH(CW+BW+16), .DEPTH(NUM_SLOTS)) u_sinfo (
        .i_clk(i_clk), .i_we(si_we), .i_waddr(sl_wa), .i_wdata(si_wd),
        .i_raddr(sl_ra), .o_rdata(si_rd));
    fsa_ram #(.WIDTH(LW), .DEPTH(1 << BW)) u_fill (
        .i_clk(i_clk), .i_we(bf_we), .i_waddr(bf_wa), .i_wdata(fl_wd),
        .i_raddr(bf_ra), .o_rdata(fl_rd));
    fsa_ram #(.WIDTH(LW+BW+1+FW), .DEPTH(1 << BW)) u_binfo (
        .i_clk(i_clk), .i_we(bi_we), .i_waddr(bf_wa), .i_wdata(bi_wd),
        .i_raddr(bf_ra), .o_rdata(bi_rd));

    logic [4:0]  in_fmt;
    logic [14:0] in_req;
    logic [11:0] in_id;
    logic [16:0] rnd;
    logic [16:0] maxsz;
    logic [LW-1:0] b_lim;
    logic [BW:0] b_older;
    logic [FW-1:0] b_kind;
    logic [CW-1:0] s_cls;
    logic [BW-1:0] s_buf;
    logic [15:0] s_start;
    logic [LW-1:0] room;
    logic fit;
    logic [HW-1:0] rel_h;

    assign in_fmt = s_axis_tdata[4:0];
    assign in_req = s_axis_tdata[19:5];
    assign in_id  = s_axis_tdata[31:20];
    assign rnd = ((17'(in_req) + 17'((1 << GRAIN_SHIFT) - 1)) >> GRAIN_SHIFT) << GRAIN_SHIFT;
    assign maxsz = 17'(NUM_SIZE_CLASSES << GRAIN_SHIFT);
    assign {b_lim, b_older, b_kind} = bi_rd;
    assign {s_cls, s_buf, s_start} = si_rd;
    assign room = b_lim - fl_rd;
    assign fit = (b_lim >= fl_rd) && (room >= LW'(r_size))
                 && (r_slots_used < (SW+1)'(NUM_SLOTS));
    assign rel_h = HW'((32'(b_kind) < NUM_FORMATS ? 32'(b_kind) : 32'd0) * NUM_SIZE_CLASSES)
                   + HW'(s_cls);

    assign s_axis_tready = (r_state == S_IDLE);

    always_comb begin
        hd_we = 1'b0; hd_wa = r_h; hd_wd = '0; hd_ra = r_h;
        sl_we = 1'b0; sl_wa = r_slots_used[SW-1:0]; sl_ra = r_id;
        lk_wd = '0; si_we = 1'b0;
        si_wd = {r_cls, r_cur[BW-1:0], fl_rd[15:0]};
        bf_we = 1'b0; bf_wa = r_cur[BW-1:0]; fl_wd = fl_rd + LW'(r_size);
        bi_we = 1'b0; bi_wd = '0;
        bf_ra = r_cur[BW-1:0] - BW'(1);
        case (r_state)
            S_CLEAR: begin
                hd_we = 1'b1; hd_wa = r_clr;
            end
            S_HEADW: begin
                sl_ra = SW'(hd_rd - 1'b1);
            end
            S_POP: begin
                hd_we = 1'b1; hd_wd = lk_rd;
            end
            S_CHECK: begin
                bf_wa = r_cur[BW-1:0] - BW'(1);
                if (r_cur != '0 && fit) begin
                    bf_we = 1'b1; sl_we = 1'b1; si_we = 1'b1;
                    si_wd = {r_cls, bf_wa, fl_rd[15:0]};
                end else if (!(r_cur != '0 && r_steps < (BW+1)'(NUM_BUFFERS)
                          && b_older != '0 && r_steps + 1'b1 < (BW+1)'(NUM_BUFFERS))
                          && r_bufs_used < (BW+1)'(NUM_BUFFERS)
                          && r_slots_used < (SW+1)'(NUM_SLOTS)) begin
                    bf_wa = r_bufs_used[BW-1:0];
                    bf_we = 1'b1; bi_we = 1'b1; sl_we = 1'b1; si_we = 1'b1;
                    fl_wd = LW'(r_size);
                    bi_wd = {(LW'(r_cap) > LW'(r_size)) ? LW'(r_cap) : LW'(r_size),
                             r_newest[r_fmt], r_fmt};
                    si_wd = {r_cls, bf_wa, 16'd0};
                end
            end
            S_RELBUF: begin
                bf_ra = s_buf;
            end
            S_RELHD: begin
                hd_ra = rel_h;
            end
            S_RELW: begin
                hd_we = 1'b1;
                hd_wd = (SW+1)'(r_id) + 1'b1;
                sl_we = 1'b1;
                sl_wa = r_id;
                lk_wd = hd_rd;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cap <= 16'd16384;
            r_clr <= '0;
            r_slots_used <= '0;
            r_bufs_used <= '0;
            m_axis_tvalid <= 1'b0;
            r_tdata <= '0;
            for (int i = 0; i < NUM_FORMATS; i++) begin
                r_newest[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (m_axis_tvalid && m_axis_tready && r_state != S_OUT) begin
                m_axis_tvalid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == HW'(HC - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_fmt <= FW'(in_fmt);
                        r_size <= rnd[15:0];
                        r_cls <= CW'((rnd >> GRAIN_SHIFT) - 17'd1);
                        r_h <= HW'(32'(in_fmt) * NUM_SIZE_CLASSES
                               + 32'((rnd >> GRAIN_SHIFT) - 17'd1));
                        r_id <= SW'(in_id);
                        r_out <= '0;
                        if (s_axis_tuser == KIND_RELEASE) begin
                            if ((SW+1)'(in_id) >= r_slots_used
                                || 32'(in_id) >= NUM_SLOTS) begin
                                r_out[2:0] <= ST_BADSLOT;
                                r_state <= S_OUT;
                            end else begin
                                r_state <= S_RELRD;
                            end
                        end else if (32'(in_fmt) >= NUM_FORMATS || rnd == '0
                                     || rnd > maxsz) begin
                            r_out[2:0] <= ST_BADSIZE;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_HEAD;
                        end
                    end
                end
                S_HEAD: r_state <= S_HEADW;
                S_HEADW: begin
                    if (hd_rd != '0) begin
                        r_id <= SW'(hd_rd - 1'b1);
                        r_state <= S_POP;
                    end else begin
                        r_cur <= r_newest[r_fmt];
                        r_steps <= '0;
                        r_state <= S_WALK;
                    end
                end
                S_POP: begin
                    r_out <= {5'd0, 15'(r_size), s_start, 5'(s_buf),
                              12'(r_id), ST_REUSED};
                    r_state <= S_OUT;
                end
                S_WALK: begin
                    if (r_cur == '0) begin
                        r_state <= S_CHECK;
                    end else begin
                        r_state <= S_WALKW;
                    end
                end
                S_WALKW: r_state <= S_CHECK;
                S_CHECK: begin
                    if (r_cur != '0 && fit) begin
                        r_slots_used <= r_slots_used + 1'b1;
                        r_out <= {5'd0, 15'(r_size), fl_rd[15:0],
                                  5'(r_cur - 1'b1), 12'(r_slots_used), ST_CARVED};
                        r_state <= S_OUT;
                    end else if (r_cur != '0 && b_older != '0
                                 && r_steps + 1'b1 < (BW+1)'(NUM_BUFFERS)) begin
                        r_cur <= b_older;
                        r_steps <= r_steps + 1'b1;
                        r_state <= S_WALKW;
                    end else if (r_bufs_used < (BW+1)'(NUM_BUFFERS)
                                 && r_slots_used < (SW+1)'(NUM_SLOTS)) begin
                        r_bufs_used <= r_bufs_used + 1'b1;
                        r_slots_used <= r_slots_used + 1'b1;
                        r_newest[r_fmt] <= r_bufs_used + 1'b1;
                        r_out <= {5'd0, 15'(r_size), 16'd0, 5'(r_bufs_used),
                                  12'(r_slots_used), ST_NEWBUF};
                        r_state <= S_OUT;
                    end else begin
                        r_out[2:0] <= ST_NOSPACE;
                        r_state <= S_OUT;
                    end
                end
                S_RELRD: r_state <= S_RELBUF;
                S_RELBUF: r_state <= S_RELHD;
                S_RELHD: begin
                    r_h <= rel_h;
                    r_state <= S_RELW;
                end
                S_RELW: begin
                    r_out[2:0] <= ST_RELEASED;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!m_axis_tvalid || m_axis_tready) begin
                        m_axis_tvalid <= 1'b1;
                        r_tdata <= r_out;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tdata = r_tdata;
endmodule

// ===== src/fsa_ram.sv =====
module fsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
